>>> sv/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Shared constants and types for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int COORD_BITS_DEF       = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 15;

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } tun_flags_t;

endpackage

>>> sv/tun_cross.sv
// ----------------------------------------------------------------------------
// tun_cross
// Edge vectors, partial products and cross product magnitudes (3 stages).
// ----------------------------------------------------------------------------
module tun_cross #(
    parameter  int COORD_BITS = tun_pkg::COORD_BITS_DEF,
    localparam int EW         = COORD_BITS + 1,
    localparam int PW         = 2 * EW,
    localparam int NW         = PW + 1,
    localparam int MW         = NW - 1
) (
    input  logic                         clk,
    input  logic [2:0]                   en,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic signed [COORD_BITS-1:0] a_z,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic signed [COORD_BITS-1:0] b_z,
    input  logic signed [COORD_BITS-1:0] c_x,
    input  logic signed [COORD_BITS-1:0] c_y,
    input  logic signed [COORD_BITS-1:0] c_z,
    output logic [MW-1:0]                mag [3],
    output tun_pkg::tun_flags_t          flags
);

    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [PW-1:0] prod_reg [6];
    logic signed [NW-1:0] n_next [3];
    logic [MW-1:0]        mag_reg [3];
    tun_pkg::tun_flags_t  flags_reg;
    tun_pkg::tun_flags_t  flags_next;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            e1_reg[0] <= EW'(b_x) - EW'(a_x);
            e1_reg[1] <= EW'(b_y) - EW'(a_y);
            e1_reg[2] <= EW'(b_z) - EW'(a_z);
            e2_reg[0] <= EW'(c_x) - EW'(a_x);
            e2_reg[1] <= EW'(c_y) - EW'(a_y);
            e2_reg[2] <= EW'(c_z) - EW'(a_z);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            prod_reg[0] <= e1_reg[1] * e2_reg[2];
            prod_reg[1] <= e1_reg[2] * e2_reg[1];
            prod_reg[2] <= e1_reg[2] * e2_reg[0];
            prod_reg[3] <= e1_reg[0] * e2_reg[2];
            prod_reg[4] <= e1_reg[0] * e2_reg[1];
            prod_reg[5] <= e1_reg[1] * e2_reg[0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_next[i] = NW'(prod_reg[2*i]) - NW'(prod_reg[2*i+1]);
        end
        for (int i = 0; i < 3; i++)
        begin
            flags_next.neg[i] = n_next[i][NW-1];
        end
        flags_next.degen = (n_next[0] == '0) && (n_next[1] == '0) && (n_next[2] == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= n_next[i][NW-1] ? MW'(-n_next[i]) : MW'(n_next[i]);
            end
            flags_reg <= flags_next;
        end
    end

    assign mag   = mag_reg;
    assign flags = flags_reg;

endmodule

>>> sv/tun_norm.sv
// ----------------------------------------------------------------------------
// tun_norm
// Squares, squared length and initial remainders for the digit recurrence.
// ----------------------------------------------------------------------------
module tun_norm #(
    parameter  int COORD_BITS       = tun_pkg::COORD_BITS_DEF,
    parameter  int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF,
    localparam int MW               = 2 * (COORD_BITS + 1),
    localparam int SW               = 2 * MW + 2,
    localparam int TW               = 2 * MW + 2 * NORMAL_FRAC_BITS + 2,
    localparam int W                = TW + 3
) (
    input  logic                 clk,
    input  logic [2:0]           en,
    input  logic [MW-1:0]        mag [3],
    input  tun_pkg::tun_flags_t  flags_in,
    output logic signed [W-1:0]  r_out [3],
    output logic signed [W-1:0]  b_out [3],
    output logic [SW-1:0]        s_out,
    output tun_pkg::tun_flags_t  flags_out
);

    logic [2*MW-1:0]       sq_reg [3];
    logic [2*MW-1:0]       sqp_reg [3];
    logic [SW-1:0]         s_reg;
    logic [SW-1:0]         s2_reg;
    logic signed [W-1:0]   r_reg [3];
    logic signed [W-1:0]   b_reg [3];
    tun_pkg::tun_flags_t   f3_reg;
    tun_pkg::tun_flags_t   f4_reg;
    tun_pkg::tun_flags_t   f5_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= mag[i] * mag[i];
            end
            f3_reg <= flags_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s_reg   <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            sqp_reg <= sq_reg;
            f4_reg  <= f3_reg;
        end
    end

    // remainder starts at 4 m^2 2^(2F) - S, running product at -S
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                r_reg[i] <= $signed(W'(TW'(sqp_reg[i]) << (2 * NORMAL_FRAC_BITS + 2)))
                            - $signed(W'(s_reg));
                b_reg[i] <= -$signed(W'(s_reg));
            end
            s2_reg <= s_reg;
            f5_reg <= f4_reg;
        end
    end

    assign r_out     = r_reg;
    assign b_out     = b_reg;
    assign s_out     = s2_reg;
    assign flags_out = f5_reg;

endmodule

>>> sv/tun_digit.sv
// ----------------------------------------------------------------------------
// tun_digit
// One quotient bit of the rounded unit magnitude for all three lanes.
// ----------------------------------------------------------------------------
module tun_digit #(
    parameter  int COORD_BITS       = tun_pkg::COORD_BITS_DEF,
    parameter  int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF,
    parameter  int BIT              = 0,
    localparam int MW               = 2 * (COORD_BITS + 1),
    localparam int SW               = 2 * MW + 2,
    localparam int TW               = 2 * MW + 2 * NORMAL_FRAC_BITS + 2,
    localparam int W                = TW + 3,
    localparam int QW               = NORMAL_FRAC_BITS + 1
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [W-1:0]  r_in [3],
    input  logic signed [W-1:0]  b_in [3],
    input  logic [QW-1:0]        q_in [3],
    input  logic [SW-1:0]        s_in,
    input  tun_pkg::tun_flags_t  flags_in,
    output logic signed [W-1:0]  r_out [3],
    output logic signed [W-1:0]  b_out [3],
    output logic [QW-1:0]        q_out [3],
    output logic [SW-1:0]        s_out,
    output tun_pkg::tun_flags_t  flags_out
);

    logic signed [W-1:0] ds;
    logic signed [W-1:0] inc [3];
    logic signed [W-1:0] trial [3];
    logic [2:0]          acc;
    logic signed [W-1:0] r_next [3];
    logic signed [W-1:0] b_next [3];
    logic [QW-1:0]       q_next [3];

    logic signed [W-1:0] r_reg [3];
    logic signed [W-1:0] b_reg [3];
    logic [QW-1:0]       q_reg [3];
    logic [SW-1:0]       s_reg;
    tun_pkg::tun_flags_t flags_reg;

    // accept bit iff T >= (2q'-1)^2 S, tracked as remainder R and B = (2q-1) S
    always_comb
    begin
        ds = $signed(W'(s_in) << (BIT + 1));
        for (int i = 0; i < 3; i++)
        begin
            inc[i]    = (b_in[i] <<< 1) + ds;
            trial[i]  = r_in[i] - (inc[i] <<< (BIT + 1));
            acc[i]    = ~trial[i][W-1];
            r_next[i] = acc[i] ? trial[i] : r_in[i];
            b_next[i] = acc[i] ? (b_in[i] + ds) : b_in[i];
            q_next[i] = acc[i] ? (q_in[i] | (QW'(1) << BIT)) : q_in[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg     <= r_next;
            b_reg     <= b_next;
            q_reg     <= q_next;
            s_reg     <= s_in;
            flags_reg <= flags_in;
        end
    end

    assign r_out     = r_reg;
    assign b_out     = b_reg;
    assign q_out     = q_reg;
    assign s_out     = s_reg;
    assign flags_out = flags_reg;

endmodule

>>> sv/triangle_unit_normal_top.sv
// Throughput: one triangle per cycle unless out_stall holds; bubbles collapse, so the
// pipeline keeps taking items while results wait, until every stage holds one.
// Each quotient bit of the three components is one pipeline stage.
// Reset (rst_n, async, active low) clears all stage valid bits; no data is cleared.
// ----------------------------------------------------------------------------
// triangle_unit_normal_top
// Unit facet normal of a triangle in signed Q1.F, rounded to nearest.
// ----------------------------------------------------------------------------
module triangle_unit_normal_top #(
    parameter int COORD_BITS       = tun_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [COORD_BITS-1:0]       a_x,
    input  logic signed [COORD_BITS-1:0]       a_y,
    input  logic signed [COORD_BITS-1:0]       a_z,
    input  logic signed [COORD_BITS-1:0]       b_x,
    input  logic signed [COORD_BITS-1:0]       b_y,
    input  logic signed [COORD_BITS-1:0]       b_z,
    input  logic signed [COORD_BITS-1:0]       c_x,
    input  logic signed [COORD_BITS-1:0]       c_y,
    input  logic signed [COORD_BITS-1:0]       c_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [NORMAL_FRAC_BITS:0]   normal_x,
    output logic signed [NORMAL_FRAC_BITS:0]   normal_y,
    output logic signed [NORMAL_FRAC_BITS:0]   normal_z,
    output logic                               degenerate
);

    localparam int MW  = 2 * (COORD_BITS + 1);
    localparam int SW  = 2 * MW + 2;
    localparam int TW  = 2 * MW + 2 * NORMAL_FRAC_BITS + 2;
    localparam int W   = TW + 3;
    localparam int QW  = NORMAL_FRAC_BITS + 1;
    localparam int ND  = NORMAL_FRAC_BITS + 1;
    localparam int NS  = ND + 7;
    localparam logic [QW-1:0] TOP = QW'(1) << NORMAL_FRAC_BITS;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS:0]   rdy;

    logic [MW-1:0]       mag [3];
    tun_pkg::tun_flags_t cross_flags;

    logic signed [W-1:0] r_st [ND+1][3];
    logic signed [W-1:0] b_st [ND+1][3];
    logic [QW-1:0]       q_st [ND+1][3];
    logic [SW-1:0]       s_st [ND+1];
    tun_pkg::tun_flags_t f_st [ND+1];

    logic [QW-1:0]       val_next [3];
    logic [QW-1:0]       val_reg [3];
    logic                degen_reg;

    always_comb
    begin
        rdy[NS] = ~out_stall;
        for (int i = NS - 1; i >= 0; i--)
        begin
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        end
        for (int i = 0; i < NS; i++)
        begin
            if (rdy[i])
            begin
                vld_next[i] = (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
            end
            else
            begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = ~rdy[0];
    assign out_valid = vld_reg[NS-1];

    tun_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk   (clk),
        .en    (rdy[2:0]),
        .a_x   (a_x),
        .a_y   (a_y),
        .a_z   (a_z),
        .b_x   (b_x),
        .b_y   (b_y),
        .b_z   (b_z),
        .c_x   (c_x),
        .c_y   (c_y),
        .c_z   (c_z),
        .mag   (mag),
        .flags (cross_flags)
    );

    tun_norm #(
        .COORD_BITS       (COORD_BITS),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_norm (
        .clk       (clk),
        .en        (rdy[5:3]),
        .mag       (mag),
        .flags_in  (cross_flags),
        .r_out     (r_st[0]),
        .b_out     (b_st[0]),
        .s_out     (s_st[0]),
        .flags_out (f_st[0])
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_st[0][i] = '0;
        end
    end

    for (genvar k = 0; k < ND; k++)
    begin : g_digit
        tun_digit #(
            .COORD_BITS       (COORD_BITS),
            .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
            .BIT              (NORMAL_FRAC_BITS - k)
        ) u_digit (
            .clk       (clk),
            .en        (rdy[6+k]),
            .r_in      (r_st[k]),
            .b_in      (b_st[k]),
            .q_in      (q_st[k]),
            .s_in      (s_st[k]),
            .flags_in  (f_st[k]),
            .r_out     (r_st[k+1]),
            .b_out     (b_st[k+1]),
            .q_out     (q_st[k+1]),
            .s_out     (s_st[k+1]),
            .flags_out (f_st[k+1])
        );
    end

    // sign, saturation of +1.0, zero on degenerate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (f_st[ND].degen)
            begin
                val_next[i] = '0;
            end
            else if (f_st[ND].neg[i])
            begin
                val_next[i] = -q_st[ND][i];
            end
            else if (q_st[ND][i] == TOP)
            begin
                val_next[i] = TOP - QW'(1);
            end
            else
            begin
                val_next[i] = q_st[ND][i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NS-1])
        begin
            val_reg   <= val_next;
            degen_reg <= f_st[ND].degen;
        end
    end

    assign normal_x   = $signed(val_reg[0]);
    assign normal_y   = $signed(val_reg[1]);
    assign normal_z   = $signed(val_reg[2]);
    assign degenerate = degen_reg;

endmodule

>>> sv/tun_checker.sv
// ----------------------------------------------------------------------------
// tun_checker
// Port-level checks on the unit normal pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module tun_checker #(
    parameter int COORD_BITS       = tun_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic signed [COORD_BITS-1:0]     a_x,
    input  logic signed [COORD_BITS-1:0]     a_y,
    input  logic signed [COORD_BITS-1:0]     a_z,
    input  logic signed [COORD_BITS-1:0]     b_x,
    input  logic signed [COORD_BITS-1:0]     b_y,
    input  logic signed [COORD_BITS-1:0]     b_z,
    input  logic signed [COORD_BITS-1:0]     c_x,
    input  logic signed [COORD_BITS-1:0]     c_y,
    input  logic signed [COORD_BITS-1:0]     c_z,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic signed [NORMAL_FRAC_BITS:0] normal_x,
    input  logic signed [NORMAL_FRAC_BITS:0] normal_y,
    input  logic signed [NORMAL_FRAC_BITS:0] normal_z,
    input  logic                             degenerate
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(a_x) && $stable(a_y) && $stable(a_z)
                                 && $stable(b_x) && $stable(b_y) && $stable(b_z)
                                 && $stable(c_x) && $stable(c_y) && $stable(c_z))
        else $error("input transfer changed during stall");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output valid dropped during stall");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(normal_x) && $stable(normal_y)
                                   && $stable(normal_z) && $stable(degenerate))
        else $error("output payload changed during stall");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
        else $error("degenerate result with nonzero normal");

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |-> normal_x != '0 || normal_y != '0 || normal_z != '0)
        else $error("nondegenerate result with zero normal");

endmodule

bind triangle_unit_normal_top tun_checker #(
    .COORD_BITS       (COORD_BITS),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_tun_checker (.*);
